/* hdl/ssm_pkg.sv */
`default_nettype none
package ssm_pkg;

    localparam int KEY_MAX  = 16;
    localparam int POS_BITS = 24;
    localparam int LEN_W    = $clog2(KEY_MAX + 1);
    localparam int IDX_W    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int WIN_D    = (KEY_MAX > 1) ? KEY_MAX - 1 : 1;
    localparam int CFG_W    = 64;
    localparam int CIDX_W   = 2;

    localparam logic [CIDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CIDX_W-1:0] REG_KEY_LEN  = 2'd2;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] total;
        logic                done;
    } t_result;

endpackage
`default_nettype wire

/* hdl/ssm_compare.sv */
`default_nettype none
module ssm_compare
    import ssm_pkg::*;
(
    input  wire t_byte                   i_cur,
    input  wire t_byte [WIN_D-1:0]       i_window,
    input  wire t_byte [KEY_MAX-1:0]     i_key,
    input  wire logic  [LEN_W-1:0]       i_len,
    input  wire logic  [LEN_W-1:0]       i_seen,
    output logic                         o_hit
);

    t_byte [KEY_MAX-1:0] w_ext;
    logic  [KEY_MAX-1:0] w_lane_ok;
    logic  [LEN_W:0]     w_have;

    // w_ext[k]: byte k positions back from the current one
    always_comb begin
        w_ext[0] = i_cur;
        for (int k = 1; k < KEY_MAX; k++) begin
            w_ext[k] = i_window[k-1];
        end
    end

    // lane i checks key byte i against the byte len-1-i back
    always_comb begin
        logic [LEN_W-1:0] off;
        for (int i = 0; i < KEY_MAX; i++) begin
            off = i_len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < i_len) begin
                w_lane_ok[i] = (w_ext[off[IDX_W-1:0]] == i_key[i]);
            end else begin
                w_lane_ok[i] = 1'b1;
            end
        end
    end

    assign w_have = {1'b0, i_seen} + (LEN_W+1)'(1);
    assign o_hit  = (i_len != '0) && (w_have >= {1'b0, i_len}) && (&w_lane_ok);

endmodule
`default_nettype wire

/* hdl/ssm_outbuf.sv */
`default_nettype none
module ssm_outbuf
    import ssm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_res
);

    logic    r_out_vld, n_out_vld;
    logic    r_skd_vld, n_skd_vld;
    t_result r_out, n_out;
    t_result r_skd, n_skd;
    logic    w_take;

    assign w_take = r_out_vld && !i_stall;

    always_comb begin
        n_out_vld = r_out_vld;
        n_skd_vld = r_skd_vld;
        n_out     = r_out;
        n_skd     = r_skd;
        if (r_skd_vld) begin
            if (w_take) begin
                n_out     = r_skd;
                n_skd_vld = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_vld || w_take) begin
                n_out     = i_res;
                n_out_vld = 1'b1;
            end else begin
                n_skd     = i_res;
                n_skd_vld = 1'b1;
            end
        end else if (w_take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign o_full  = r_skd_vld;
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule
`default_nettype wire

/* hdl/stream_substring_matcher.sv */
// stream_substring_matcher: finds every occurrence, overlaps included, of a
// key of up to 16 bytes in a byte stream.
// Input channel: one text byte per word with a last flag; a word is taken
// when i_in_valid is high and o_in_stall is low; one word per cycle unless stalled.
// Output channel: a word for each byte that ends an occurrence, and always
// one for the last byte (o_text_done), carrying the running count.
// Bytes that neither match nor end the text give no word.
// Results are registered in the output buffer; the whole key is compared
// against the window combinationally, as the byte is accepted.
// Stall: a two-word output buffer lets input run on while one result waits;
// o_in_stall rises only when both are occupied.
// Config: key bytes and length are written through i_cfg_* while idle;
// o_cfg_ready is always high. Indexes 0/1/2: key low, key high, length.
// Reset clears key, window, position and count; the last byte clears the
// text state again, keeping the key.
`default_nettype none
module stream_substring_matcher
    import ssm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [7:0]          i_text_byte,
    input  wire logic                i_last_byte,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_match_found,
    output logic [POS_BITS-1:0]      o_match_start,
    output logic [POS_BITS-1:0]      o_match_total,
    output logic                     o_text_done,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CIDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]    i_cfg_data
);

    logic [CFG_W-1:0]    r_key_low;
    logic [CFG_W-1:0]    r_key_high;
    logic [4:0]          r_key_len;
    t_byte [WIN_D-1:0]   r_window;
    logic [POS_BITS-1:0] r_pos;
    logic [LEN_W-1:0]    r_seen;
    logic [POS_BITS-1:0] r_count, n_count;

    t_byte [KEY_MAX-1:0] w_key;
    logic [LEN_W-1:0]    w_len;
    logic                w_hit;
    logic                w_acc;
    logic                w_push;
    logic                w_full;
    t_result             w_res;
    t_result             w_out;

    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LEN:  r_key_len  <= i_cfg_data[4:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < KEY_MAX; i++) begin
            if (i < 8) begin
                w_key[i] = r_key_low[8*(i%8) +: 8];
            end else begin
                w_key[i] = r_key_high[8*(i%8) +: 8];
            end
        end
    end

    assign w_len = (r_key_len > 5'(KEY_MAX)) ? LEN_W'(KEY_MAX) : LEN_W'(r_key_len);

    ssm_compare u_compare (
        .i_cur    (i_text_byte),
        .i_window (r_window),
        .i_key    (w_key),
        .i_len    (w_len),
        .i_seen   (r_seen),
        .o_hit    (w_hit)
    );

    assign n_count = (w_hit && r_count != POS_MAX) ? r_count + POS_BITS'(1) : r_count;

    always_comb begin
        w_res.found = w_hit;
        w_res.start = w_hit ? (r_pos - POS_BITS'(w_len) + POS_BITS'(1)) : '0;
        w_res.total = n_count;
        w_res.done  = i_last_byte;
    end

    assign w_push = w_acc && (w_hit || i_last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_pos    <= '0;
            r_seen   <= '0;
            r_count  <= '0;
        end else if (w_acc) begin
            if (i_last_byte) begin
                r_window <= '0;
                r_pos    <= '0;
                r_seen   <= '0;
                r_count  <= '0;
            end else begin
                for (int k = WIN_D - 1; k > 0; k--) begin
                    r_window[k] <= r_window[k-1];
                end
                r_window[0] <= i_text_byte;
                r_pos       <= r_pos + POS_BITS'(1);
                r_count     <= n_count;
                if (r_seen < LEN_W'(KEY_MAX)) begin
                    r_seen <= r_seen + LEN_W'(1);
                end
            end
        end
    end

    ssm_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (w_out)
    );

    assign o_in_stall    = w_full;
    assign o_match_found = w_out.found;
    assign o_match_start = w_out.start;
    assign o_match_total = w_out.total;
    assign o_text_done   = w_out.done;

    // spare buffer only fills behind a waiting word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid word without output word");

    // every word is a match or the end of a text
    a_word_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_match_found || o_text_done))
        else $error("output word with neither match nor done");

    // a match always counts at least one occurrence
    a_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_match_found) |-> (o_match_total != '0))
        else $error("match word with zero total");

    // after a push, the output holds a valid word next cycle
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_out_valid)
        else $error("accepted result not presented");

endmodule
`default_nettype wire
